@@ rtl/core/hhbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hhbp_pkg
// Shared types and constants of the HTTP header block parser: the item and
// result payloads, the configuration set, register reset values, status codes and register indexes.
// ----------------------------------------------------------------------------
package hhbp_pkg;

  // Width of the parsed content length
  localparam int LENGTH_BITS = 24;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCK_BYTES  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEADER_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_KEY_BYTES    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE_BYTES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_BYTES   = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_MAX_BLOCK_BYTES  = 16'd16384;
  localparam logic [7:0]  RST_MAX_HEADER_COUNT = 8'd100;
  localparam logic [7:0]  RST_MAX_KEY_BYTES    = 8'd128;
  localparam logic [13:0] RST_MAX_VALUE_BYTES  = 14'd8192;
  localparam logic [23:0] RST_MAX_BODY_BYTES   = 24'd1048576;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BLOCK_LONG  = 3'd1;
  localparam logic [2:0] ST_NO_COLON    = 3'd2;
  localparam logic [2:0] ST_TOO_MANY    = 3'd3;
  localparam logic [2:0] ST_KEY_LONG    = 3'd4;
  localparam logic [2:0] ST_VALUE_LONG  = 3'd5;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd6;
  localparam logic [2:0] ST_LENGTH_DIFF = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       end_of_block;
    logic       is_http11;
  } item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic                   length_present;
    logic [LENGTH_BITS-1:0] content_length;
    logic                   keep_alive;
    logic [7:0]             header_count;
  } result_t;

  typedef struct packed {
    logic [15:0] max_block_bytes;
    logic [7:0]  max_header_count;
    logic [7:0]  max_key_bytes;
    logic [13:0] max_value_bytes;
    logic [23:0] max_body_bytes;
  } cfg_t;

endpackage

@@ rtl/core/http_header_block_parser.sv @@
// ----------------------------------------------------------------------------
// http_header_block_parser
// Byte-serial HTTP/1.1 header block checker with content length extraction.
// ----------------------------------------------------------------------------
// The parser takes one header byte per transaction and sustains one
// transaction per clock. Each accepted byte lands in an input register; from
// there a single pass of logic advances the line and block state
// (CR/LF framing, key match, value trim, decimal length parse, limit checks)
// and, on the transaction that closes the block, loads one result into the
// output register. That combinational state update is what bounds the clock.
// Input stall rises only when a block-closing transaction reaches the logic
// while the previous result still waits at the output. Configuration writes
// take effect on the next edge and are meant for idle periods between blocks.
// ----------------------------------------------------------------------------
module http_header_block_parser (
  input  logic                                clk,
  input  logic                                rst,
  // byte transactions
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hhbp_pkg::item_t                     in_data,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_stall,
  output hhbp_pkg::result_t                   out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [hhbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hhbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hhbp_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_q_valid;
  logic    fire;
  result_t result;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_block_bytes  <= RST_MAX_BLOCK_BYTES;
      cfg.max_header_count <= RST_MAX_HEADER_COUNT;
      cfg.max_key_bytes    <= RST_MAX_KEY_BYTES;
      cfg.max_value_bytes  <= RST_MAX_VALUE_BYTES;
      cfg.max_body_bytes   <= RST_MAX_BODY_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_BLOCK_BYTES:  cfg.max_block_bytes  <= cfg_data[15:0];
        REG_MAX_HEADER_COUNT: cfg.max_header_count <= cfg_data[7:0];
        REG_MAX_KEY_BYTES:    cfg.max_key_bytes    <= cfg_data[7:0];
        REG_MAX_VALUE_BYTES:  cfg.max_value_bytes  <= cfg_data[13:0];
        REG_MAX_BODY_BYTES:   cfg.max_body_bytes   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Process the held byte unless it closes a block and the output slot
  // is occupied and stalled.
  assign fire     = in_q_valid && (!in_q.end_of_block || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;

  // Input register: refill whenever the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  hhbp_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Output register: load on block close, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_q.end_of_block) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_q.end_of_block) begin
      out_data <= result;
    end
  end

  // A failed block reports nothing but its status
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      !out_data.length_present && out_data.content_length == '0 &&
      !out_data.keep_alive && out_data.header_count == '0)
    else $error("error result carries nonzero fields");

  // Absent length reads as zero
  a_length_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.length_present |-> out_data.content_length == '0)
    else $error("content length without length header");

  // Stall only when a block close meets a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && in_q.end_of_block && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Accepted header count respects the configured limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |->
      out_data.header_count <= cfg.max_header_count)
    else $error("header count above limit");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

@@ rtl/core/hhbp_engine.sv @@
// ----------------------------------------------------------------------------
// hhbp_engine
// Line and block state of the header parser, updated once per accepted transaction.
// ----------------------------------------------------------------------------
module hhbp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  hhbp_pkg::item_t   item,
  input  hhbp_pkg::cfg_t    cfg,
  output hhbp_pkg::result_t result
);
  import hhbp_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [1:0] DS_EMPTY = 2'd0;
  localparam logic [1:0] DS_OK    = 2'd1;
  localparam logic [1:0] DS_BAD   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;

  localparam logic [8:0]  KEY_SAT   = 9'd511;
  localparam logic [14:0] VAL_SAT   = 15'd32767;
  localparam logic [16:0] BYTES_SAT = 17'd131071;
  localparam logic [8:0]  CLEN_LEN  = 9'd14;
  localparam logic [8:0]  CONN_LEN  = 9'd10;

  localparam logic [71:0] KA_HEAD = "keep-aliv";
  localparam logic [7:0]  KA_TAIL = "e";

  localparam logic [7:0] CLEN_CHARS [16] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h",
    8'h00, 8'h00
  };
  localparam logic [7:0] CONN_CHARS [16] = '{
    "c", "o", "n", "n", "e", "c", "t", "i", "o", "n",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0]             phase;
    logic [8:0]             key_len;
    logic [1:0]             kflags;    // bit0 content-length, bit1 connection
    logic [14:0]            val_len;
    logic [14:0]            ws_run;
    logic [LENGTH_BITS-1:0] acc;
    logic [1:0]             dstat;
    logic [71:0]            recent;    // oldest byte in the top lane
    logic                   ka_seen;
  } line_t;

  typedef struct packed {
    logic                   cr_pending;
    logic [1:0]             conn_flags; // bit0 seen, bit1 keep-alive
    logic [LENGTH_BITS-1:0] stored_len;
    logic                   stored_valid;
    logic [7:0]             lines;
    logic [16:0]            bytes;
    logic [2:0]             first_error;
  } block_t;

  localparam line_t  LINE_CLEAR  = '{kflags: 2'b11, dstat: DS_EMPTY, default: '0};
  localparam block_t BLOCK_CLEAR = '{default: '0};

  // One content byte of the current line
  function automatic line_t content_step(line_t s, logic [7:0] c,
                                         logic [LENGTH_BITS-1:0] lim);
    line_t                  n;
    logic [7:0]             lc;
    logic [LENGTH_BITS+3:0] nxt;
    logic [15:0]            vsum;
    n    = s;
    lc   = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    nxt  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (LENGTH_BITS+4)'(c[3:0]);
    vsum = {1'b0, s.val_len} + {1'b0, s.ws_run} + 16'd1;
    if (s.phase == PH_VALUE) begin
      if (s.recent == KA_HEAD && lc == KA_TAIL) n.ka_seen = 1'b1;
      n.recent = {s.recent[63:0], lc};
      if (c == CH_SP || c == CH_TAB) begin
        // leading blanks are dropped, inner and trailing ones are counted
        if (s.val_len != '0 && s.ws_run != VAL_SAT) n.ws_run = s.ws_run + 15'd1;
      end else begin
        if (s.dstat != DS_BAD) begin
          if (c < CH_0 || c > CH_9 || s.ws_run != '0) begin
            n.dstat = DS_BAD;
          end else if (nxt > {4'b0, lim}) begin
            n.dstat = DS_BAD;
          end else begin
            n.acc   = nxt[LENGTH_BITS-1:0];
            n.dstat = DS_OK;
          end
        end
        n.val_len = (vsum > {1'b0, VAL_SAT}) ? VAL_SAT : vsum[14:0];
        n.ws_run  = '0;
      end
    end else if (c == CH_COLON) begin
      n.phase  = PH_VALUE;
      n.recent = '0;
    end else begin
      n.phase = PH_KEY;
      if (s.key_len >= CLEN_LEN || CLEN_CHARS[s.key_len[3:0]] != lc) n.kflags[0] = 1'b0;
      if (s.key_len >= CONN_LEN || CONN_CHARS[s.key_len[3:0]] != lc) n.kflags[1] = 1'b0;
      if (s.key_len != KEY_SAT) n.key_len = s.key_len + 9'd1;
    end
    return n;
  endfunction

  // Close a line: check it and fold it into the block state
  function automatic block_t finish_line(line_t s, block_t b, cfg_t c);
    block_t n;
    logic   is_clen;
    logic   is_conn;
    n       = b;
    is_clen = s.kflags[0] && s.key_len == CLEN_LEN;
    is_conn = s.kflags[1] && s.key_len == CONN_LEN;
    if (b.first_error == ST_OK) begin
      if (s.phase != PH_VALUE || s.key_len == '0) begin
        n.first_error = ST_NO_COLON;
      end else if (b.lines >= c.max_header_count) begin
        n.first_error = ST_TOO_MANY;
      end else begin
        n.lines = b.lines + 8'd1;
        if (s.key_len > {1'b0, c.max_key_bytes}) begin
          n.first_error = ST_KEY_LONG;
        end else if (s.val_len > {1'b0, c.max_value_bytes}) begin
          n.first_error = ST_VALUE_LONG;
        end else if (is_clen) begin
          if (s.dstat != DS_OK) begin
            n.first_error = ST_BAD_LENGTH;
          end else if (b.stored_valid && b.stored_len != s.acc) begin
            n.first_error = ST_LENGTH_DIFF;
          end else begin
            n.stored_len   = s.acc;
            n.stored_valid = 1'b1;
          end
        end else if (is_conn) begin
          n.conn_flags = {s.ka_seen, 1'b1};
        end
      end
    end
    return n;
  endfunction

  line_t                  line, line_next, l1, l2, l3;
  block_t                 blk, blk_next, b0, b1;
  logic [LENGTH_BITS-1:0] lim;
  logic                   has_byte, lf_finish, pre_cr, do_byte, pend_after, post_cr;
  logic                   finish;
  logic [2:0]             status;

  always_comb begin
    lim        = LENGTH_BITS'(cfg.max_body_bytes);
    has_byte   = !item.no_byte;
    lf_finish  = has_byte && blk.cr_pending && item.data_byte == CH_LF;
    pre_cr     = has_byte && blk.cr_pending && item.data_byte != CH_LF;
    do_byte    = has_byte && item.data_byte != CH_CR && !lf_finish;
    pend_after = has_byte ? (item.data_byte == CH_CR) : blk.cr_pending;
    post_cr    = item.end_of_block && pend_after;

    // a held CR that is not followed by LF is line content
    l1 = pre_cr  ? content_step(line, CH_CR, lim) : line;
    l2 = do_byte ? content_step(l1, item.data_byte, lim) : l1;
    l3 = post_cr ? content_step(l2, CH_CR, lim) : l2;

    b0 = blk;
    if (has_byte && blk.bytes != BYTES_SAT) b0.bytes = blk.bytes + 17'd1;
    b0.cr_pending = item.end_of_block ? 1'b0 : pend_after;

    finish = lf_finish || (item.end_of_block && l3.phase != PH_START);
    b1     = finish ? finish_line(l3, b0, cfg) : b0;

    status = (b1.bytes > {1'b0, cfg.max_block_bytes}) ? ST_BLOCK_LONG : b1.first_error;
    result.status = status;
    if (status == ST_OK) begin
      result.length_present = b1.stored_valid;
      result.content_length = b1.stored_valid ? b1.stored_len : '0;
      result.keep_alive     = b1.conn_flags[0] ? b1.conn_flags[1] : item.is_http11;
      result.header_count   = b1.lines;
    end else begin
      result.length_present = 1'b0;
      result.content_length = '0;
      result.keep_alive     = 1'b0;
      result.header_count   = '0;
    end

    line_next = (finish || item.end_of_block) ? LINE_CLEAR : l3;
    blk_next  = item.end_of_block ? BLOCK_CLEAR : b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= LINE_CLEAR;
      blk  <= BLOCK_CLEAR;
    end else if (step) begin
      line <= line_next;
      blk  <= blk_next;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP header block parser. Header blocks are
// built byte by byte, sent through a valid/stall channel with random gaps,
// and every result is checked field by field against a bit-accurate
// predictor of the line framing, key matching, value trimming and length
// parse. Limit registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
  import hhbp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [7:0] CR  = 8'h0D;
  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] TAB = 8'h09;

  // Saturation points of the byte, key and value counters
  localparam logic [16:0] BYTES_CAP = 17'd131071;
  localparam logic [8:0]  KEY_CAP   = 9'd511;
  localparam logic [14:0] VALUE_CAP = 15'd32767;

  localparam logic [8*14-1:0] NAME_LENGTH     = "content-length";
  localparam logic [8*10-1:0] NAME_CONNECTION = "connection";
  localparam logic [8*10-1:0] WORD_KEEPALIVE  = "keep-alive";

  typedef enum logic [1:0] {LINE_START, LINE_KEY, LINE_VALUE} line_stage_e;
  typedef enum logic [1:0] {DIGITS_NONE, DIGITS_OK, DIGITS_BAD} digit_state_e;
  typedef enum int {CLOSE_ANY, CLOSE_EMPTY_ITEM, CLOSE_ON_BYTE} close_mode_e;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  item_t                  in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  result_t                out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  http_header_block_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Parser state mirror
  // --------------------------------------------------------------------------
  logic [15:0] lim_block;
  logic [7:0]  lim_count;
  logic [7:0]  lim_key;
  logic [13:0] lim_value;
  logic [23:0] lim_body;

  line_stage_e  ln_stage;
  logic         cr_held;
  logic [8:0]   key_len;
  logic [1:0]   key_hits;      // bit 0 content-length, bit 1 connection
  logic [14:0]  val_len;
  logic [14:0]  ws_run;
  logic [23:0]  digit_acc;
  digit_state_e digit_state;
  logic [7:0]   tail_window [9];
  logic         ka_in_line;
  logic         conn_seen;
  logic         conn_ka;
  logic [23:0]  len_value;
  logic         len_known;
  logic [7:0]   line_count;
  logic [16:0]  block_bytes;
  logic [2:0]   err_code;

  result_t expected_results [$];
  int      mismatches = 0;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void reset_line();
    ln_stage    = LINE_START;
    key_len     = '0;
    key_hits    = 2'b11;
    val_len     = '0;
    ws_run      = '0;
    digit_acc   = '0;
    digit_state = DIGITS_NONE;
    foreach (tail_window[i]) tail_window[i] = '0;
    ka_in_line  = 1'b0;
  endfunction

  function automatic void reset_block();
    reset_line();
    cr_held     = 1'b0;
    conn_seen   = 1'b0;
    conn_ka     = 1'b0;
    len_value   = '0;
    len_known   = 1'b0;
    line_count  = '0;
    block_bytes = '0;
    err_code    = ST_OK;
  endfunction

  function automatic void value_char(logic [7:0] c);
    logic [7:0]  lc;
    logic        hit;
    logic [63:0] next;
    int unsigned sum;
    lc  = to_lower(c);
    // keep-alive ends on this byte when the nine bytes before it match
    hit = (lc == WORD_KEEPALIVE[7:0]);
    for (int i = 0; i < 9; i++)
      if (tail_window[i] != WORD_KEEPALIVE[8*(9-i) +: 8]) hit = 1'b0;
    if (hit) ka_in_line = 1'b1;
    for (int i = 0; i < 8; i++) tail_window[i] = tail_window[i+1];
    tail_window[8] = lc;

    if (c == " " || c == TAB) begin
      // blanks before the first real byte are trimmed, the rest held pending
      if (val_len != 0 && ws_run < VALUE_CAP) ws_run++;
      return;
    end
    if (digit_state != DIGITS_BAD) begin
      if (c < "0" || c > "9" || ws_run != 0) begin
        digit_state = DIGITS_BAD;
      end else begin
        next = 64'(digit_acc) * 64'd10 + 64'(c - "0");
        if (next > 64'(lim_body)) begin
          digit_state = DIGITS_BAD;
        end else begin
          digit_acc   = next[23:0];
          digit_state = DIGITS_OK;
        end
      end
    end
    sum     = val_len + ws_run + 1;
    val_len = (sum > VALUE_CAP) ? VALUE_CAP : sum[14:0];
    ws_run  = '0;
  endfunction

  function automatic void content_char(logic [7:0] c);
    logic [7:0] lc;
    int         k;
    if (ln_stage == LINE_VALUE) begin
      value_char(c);
      return;
    end
    if (c == ":") begin
      ln_stage = LINE_VALUE;
      foreach (tail_window[i]) tail_window[i] = '0;
      return;
    end
    ln_stage = LINE_KEY;
    lc = to_lower(c);
    k  = int'(key_len);
    if (k >= 14 || NAME_LENGTH[8*(13-k) +: 8] != lc) key_hits[0] = 1'b0;
    if (k >= 10 || NAME_CONNECTION[8*(9-k) +: 8] != lc) key_hits[1] = 1'b0;
    if (key_len < KEY_CAP) key_len++;
  endfunction

  function automatic void close_line();
    logic is_len;
    logic is_conn;
    if (err_code == ST_OK) begin
      is_len  = key_hits[0] && key_len == 14;
      is_conn = key_hits[1] && key_len == 10;
      if (ln_stage != LINE_VALUE || key_len == 0) begin
        err_code = ST_NO_COLON;
      end else if (line_count >= lim_count) begin
        err_code = ST_TOO_MANY;
      end else begin
        line_count++;
        if (key_len > {1'b0, lim_key}) begin
          err_code = ST_KEY_LONG;
        end else if (val_len > {1'b0, lim_value}) begin
          err_code = ST_VALUE_LONG;
        end else if (is_len) begin
          if (digit_state != DIGITS_OK)
            err_code = ST_BAD_LENGTH;
          else if (len_known && len_value != digit_acc)
            err_code = ST_LENGTH_DIFF;
          else begin
            len_value = digit_acc;
            len_known = 1'b1;
          end
        end else if (is_conn) begin
          conn_seen = 1'b1;
          conn_ka   = ka_in_line;
        end
      end
    end
    reset_line();
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (block_bytes < BYTES_CAP) block_bytes++;
    if (cr_held) begin
      cr_held = 1'b0;
      if (c == LF) begin
        close_line();
        return;
      end
      content_char(CR);
    end
    if (c == CR)
      cr_held = 1'b1;
    else
      content_char(c);
  endfunction

  // Advance the mirror by one accepted transaction; queue a result at block end
  function automatic void predict_item(item_t it);
    result_t    r;
    logic [2:0] st;
    if (!it.no_byte) take_char(it.data_byte);
    if (!it.end_of_block) return;
    if (cr_held) begin
      cr_held = 1'b0;
      content_char(CR);
    end
    if (ln_stage != LINE_START) close_line();
    st = (block_bytes > {1'b0, lim_block}) ? ST_BLOCK_LONG : err_code;
    r  = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.length_present = len_known;
      r.content_length = len_known ? len_value : '0;
      r.keep_alive     = conn_seen ? conn_ka : it.is_http11;
      r.header_count   = line_count;
    end
    expected_results.push_back(r);
    reset_block();
  endfunction

  // --------------------------------------------------------------------------
  // Block builder
  // --------------------------------------------------------------------------
  item_t pending_items [$];
  item_t block_buf [$];
  int    bytes_made = 0;
  string last_length_text;

  function automatic void buf_noise();
    item_t it;
    it.data_byte    = 8'($urandom);
    it.no_byte      = 1'b1;
    it.end_of_block = 1'b0;
    it.is_http11    = 1'($urandom);
    block_buf.push_back(it);
  endfunction

  function automatic void buf_byte(logic [7:0] b);
    item_t it;
    // sprinkle empty transactions that the parser must ignore
    if ($urandom_range(0, 39) == 0) buf_noise();
    it.data_byte    = b;
    it.no_byte      = 1'b0;
    it.end_of_block = 1'b0;
    it.is_http11    = 1'($urandom);
    block_buf.push_back(it);
    bytes_made++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) buf_byte(s[i]);
  endfunction

  function automatic void add_blanks(int most);
    repeat ($urandom_range(0, most)) buf_byte($urandom_range(0, 1) ? " " : TAB);
  endfunction

  function automatic void add_raw(int lo, int hi);
    repeat ($urandom_range(lo, hi)) buf_byte(8'($urandom));
  endfunction

  function automatic string mixed_case(string s);
    string res;
    res = s;
    for (int i = 0; i < res.len(); i++)
      if (res[i] >= "a" && res[i] <= "z" && $urandom_range(0, 1)) res[i] = res[i] - 8'd32;
    return res;
  endfunction

  function automatic string random_token(int lo, int hi);
    string s;
    int    c;
    s = "";
    repeat ($urandom_range(lo, hi)) begin
      case ($urandom_range(0, 5))
        0:       c = $urandom_range("0", "9");
        1:       c = "-";
        2:       c = $urandom_range("A", "Z");
        default: c = $urandom_range("a", "z");
      endcase
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  // Close the block: end on its last byte or on a separate empty transaction
  function automatic void close_block(close_mode_e mode);
    item_t it;
    if (block_buf.size() == 0 || mode == CLOSE_EMPTY_ITEM ||
        (mode == CLOSE_ANY && $urandom_range(0, 2) == 0)) begin
      it.data_byte    = 8'($urandom);
      it.no_byte      = 1'b1;
      it.end_of_block = 1'b1;
      it.is_http11    = 1'($urandom);
      block_buf.push_back(it);
    end else begin
      it = block_buf.pop_back();
      it.end_of_block = 1'b1;
      it.is_http11    = 1'($urandom);
      block_buf.push_back(it);
    end
    foreach (block_buf[i]) pending_items.push_back(block_buf[i]);
    block_buf.delete();
    last_length_text = "";
  endfunction

  function automatic void add_length_value();
    longint n;
    string  num;
    if (last_length_text != "" && $urandom_range(0, 2) == 0) begin
      num = last_length_text;   // repeat an earlier length, mostly to agree
    end else begin
      case ($urandom_range(0, 6))
        0:       n = 0;
        1:       n = longint'(lim_body);
        2:       n = longint'(lim_body) + 1;
        3:       n = $urandom_range(0, 24'hFFFFFF);
        4:       n = 64'd99999999999;
        default: n = $urandom_range(0, 999);
      endcase
      num = $sformatf("%0d", n);
      case ($urandom_range(0, 9))
        0:       num = {"00", num};
        1:       num = {num, " 7"};
        2:       num = {num, "x"};
        3:       num = "";
        default: ;
      endcase
      last_length_text = num;
    end
    add_text(num);
  endfunction

  function automatic void add_connection_value();
    string s;
    case ($urandom_range(0, 7))
      0, 1:    s = "keep-alive";
      2:       s = "close";
      3:       s = "keep-alive, upgrade";
      4:       s = "upgrade,keep-alive";
      5:       s = "keep-aliv";
      6:       s = "xxkeep-alivexx";
      default: s = "keep- alive";
    endcase
    add_text(mixed_case(s));
  endfunction

  function automatic void add_other_value();
    case ($urandom_range(0, 5))
      0: add_raw(1, 4);
      1: add_text({random_token(1, 3), " ", random_token(1, 3)});
      default: add_text(random_token(0, 8));
    endcase
  endfunction

  function automatic void random_header();
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        add_text(mixed_case("content-length"));
        buf_byte(":");
        add_blanks(2);
        add_length_value();
      end
      3, 4: begin
        add_text(mixed_case("connection"));
        buf_byte(":");
        add_blanks(2);
        add_connection_value();
      end
      5: begin
        case ($urandom_range(0, 3))
          0:       add_text("content-lengthx");
          1:       add_text("Content-Lengt");
          2:       add_text("connections");
          default: add_text("Connectio");
        endcase
        buf_byte(":");
        add_blanks(1);
        add_length_value();
      end
      8: begin
        add_raw(1, 4);
        buf_byte(":");
        add_other_value();
      end
      9: begin
        buf_byte(":");
        add_other_value();
      end
      10: begin
        // key right at or just past the key limit, or of 15 to 40 bytes when that limit is large
        n = lim_key + $urandom_range(0, 1);
        if (n > 40) n = $urandom_range(15, 40);
        repeat (n) buf_byte(8'($urandom_range("a", "z")));
        buf_byte(":");
        add_other_value();
      end
      11: begin
        add_text(random_token(1, 6));
        buf_byte(":");
        add_blanks(2);
        n = lim_value + $urandom_range(0, 1);
        if (n > 40) n = $urandom_range(5, 40);
        repeat (n) buf_byte(8'($urandom_range(0, 4) == 0 ? " " : $urandom_range("a", "z")));
      end
      default: begin
        add_text(random_token(1, 6));
        buf_byte(":");
        add_blanks(2);
        add_other_value();
      end
    endcase
    add_blanks(2);
  endfunction

  function automatic void random_block();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 19))
        0:       ;                               // empty line
        1:       add_text(random_token(1, 6));   // line without a colon
        default: random_header();
      endcase
      buf_byte(CR);
      buf_byte(LF);
    end
    // an unterminated last line, sometimes ending in a held CR
    if ($urandom_range(0, 3) == 0) begin
      random_header();
      if ($urandom_range(0, 3) == 0) buf_byte(CR);
    end
    close_block(CLOSE_ANY);
  endfunction

  function automatic void fill_random(int budget);
    int start;
    start = bytes_made;
    while (bytes_made - start < budget) random_block();
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued transactions, hold while stalled, idle between
  // --------------------------------------------------------------------------
  int   send_gap    = 0;
  logic send_calm   = 1'b0;
  logic sender_rush = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_gap  <= 0;
      send_calm <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap <= (sender_rush || send_calm) ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // switch between gappy and back-to-back stretches now and then
      if ($urandom_range(0, 99) == 0) send_calm <= !send_calm;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, compare with the oldest prediction, stall at random
  // --------------------------------------------------------------------------
  int   recv_left      = 0;
  logic recv_calm      = 1'b0;
  logic hold_kick      = 1'b0;
  int   long_hold_left = 0;

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no block pending: status %0d", got.status);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("length_present", want.length_present, got.length_present);
    compare_field("content_length", want.content_length, got.content_length);
    compare_field("keep_alive", want.keep_alive, got.keep_alive);
    compare_field("header_count", want.header_count, got.header_count);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_left = 0;
      recv_calm <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        recv_left = recv_calm ? 0 : $urandom_range(0, 11);
      end
      out_stall <= (recv_left > 0) || (long_hold_left > 0);
      if (recv_left > 0) recv_left--;
      if ($urandom_range(0, 49) == 0) recv_calm <= !recv_calm;
    end
  end

  // Long receiver hold-off, so that results back up into the input
  always @(posedge clk) begin
    if (rst)
      long_hold_left <= 0;
    else if (hold_kick)
      long_hold_left <= HOLD_CYCLES;
    else if (long_hold_left > 0)
      long_hold_left <= long_hold_left - 1;
  end

  // Watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and phase sequencing
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MAX_BLOCK_BYTES:  lim_block = val[15:0];
      REG_MAX_HEADER_COUNT: lim_count = val[7:0];
      REG_MAX_KEY_BYTES:    lim_key   = val[7:0];
      REG_MAX_VALUE_BYTES:  lim_value = val[13:0];
      REG_MAX_BODY_BYTES:   lim_body  = val[23:0];
      default:              ;
    endcase
  endtask

  // Write all limits; drive junk in the unused upper data bits
  task automatic program_limits(logic [15:0] blk, logic [7:0] cnt, logic [7:0] key,
                                logic [13:0] val, logic [23:0] body);
    write_reg(REG_MAX_BLOCK_BYTES,  {8'($urandom), blk});
    write_reg(REG_MAX_HEADER_COUNT, {16'($urandom), cnt});
    write_reg(REG_MAX_KEY_BYTES,    {16'($urandom), key});
    write_reg(REG_MAX_VALUE_BYTES,  {10'($urandom), val});
    write_reg(REG_MAX_BODY_BYTES,   body);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every transaction is taken and every result checked
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    lim_block = RST_MAX_BLOCK_BYTES;
    lim_count = RST_MAX_HEADER_COUNT;
    lim_key   = RST_MAX_KEY_BYTES;
    lim_value = RST_MAX_VALUE_BYTES;
    lim_body  = RST_MAX_BODY_BYTES;
    reset_block();
    last_length_text = "";

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty block, bare CR LF line, held CR at block end, lone LF
    // with extreme byte values, ignored empty transaction and lone CR
    close_block(CLOSE_EMPTY_ITEM);
    buf_byte(CR);
    buf_byte(LF);
    close_block(CLOSE_EMPTY_ITEM);
    add_text("a:");
    buf_byte(CR);
    close_block(CLOSE_ON_BYTE);
    buf_byte(8'h00);
    buf_byte(":");
    buf_byte(8'hFF);
    buf_byte(LF);
    close_block(CLOSE_ON_BYTE);
    buf_noise();
    add_text("x:1");
    buf_byte(CR);
    buf_byte("y");
    buf_byte(CR);
    buf_byte(LF);
    close_block(CLOSE_EMPTY_ITEM);

    // Reset limits
    fill_random(150);
    wait_idle();

    // Tight limits: most blocks trip some check
    program_limits(16'd60, 8'd3, 8'd12, 14'd6, 24'd9999);
    fill_random(150);
    wait_idle();

    // All limits at their top; one key far past the largest key limit
    program_limits(16'hFFFF, 8'hFF, 8'hFF, 14'h3FFF, 24'hFFFFFF);
    repeat (300) buf_byte(8'($urandom_range("a", "z")));
    add_text(":v");
    buf_byte(CR);
    buf_byte(LF);
    close_block(CLOSE_ANY);
    fill_random(100);
    wait_idle();

    // All limits at zero: only empty blocks pass
    program_limits(16'd0, 8'd0, 8'd0, 14'd0, 24'd0);
    fill_random(40);
    wait_idle();

    // Unmapped index must leave every limit alone
    write_reg(REG_UNUSED, 24'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    program_limits(16'($urandom_range(30, 300)), 8'($urandom_range(1, 6)),
                   8'($urandom_range(2, 16)), 14'($urandom_range(1, 24)),
                   24'($urandom_range(0, 1) ? $urandom_range(0, 500)
                                            : $urandom_range(0, 24'hFFFFFF)));
    fill_random(150);
    wait_idle();

    // Back to reset limits; receiver holds off while short blocks stream in
    program_limits(RST_MAX_BLOCK_BYTES, RST_MAX_HEADER_COUNT, RST_MAX_KEY_BYTES,
                   RST_MAX_VALUE_BYTES, RST_MAX_BODY_BYTES);
    hold_kick   <= 1'b1;
    sender_rush <= 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1)) add_text("a:b");
      close_block(CLOSE_ANY);
    end
    @(negedge clk);
    hold_kick <= 1'b0;
    wait_idle();
    sender_rush <= 1'b0;

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
